@@ rtl/core/circumcircle_from_three_points_defines.svh @@
// assertion macros for the circumcircle block
`ifndef CIRCUMCIRCLE_FROM_THREE_POINTS_DEFINES_SVH
`define CIRCUMCIRCLE_FROM_THREE_POINTS_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define CCFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies result on the next edge
`define CCFP_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

@@ rtl/core/ccfp_pkg.sv @@
`default_nettype none
package ccfp_pkg;

  localparam int unsigned CCFP_COORD_WIDTH = 16;
  localparam int unsigned CENTER_W         = 31;
  localparam int unsigned DELTA_W          = 32;
  localparam int unsigned D2_W             = 64;
  localparam int unsigned ROOT_W           = 32;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned OUT_DEPTH        = 2;

  localparam longint CENTER_MIN = -(64'sd1 <<< 30);
  localparam longint CENTER_MAX = (64'sd1 <<< 30) - 64'sd1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_COLLINEAR = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic [CENTER_W-1:0]        radius;
    logic                       clockwise;
    status_t                    status;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/circumcircle_from_three_points.sv @@
// circumcircle of three integer points
//
// input channel: a point triple is transferred on a rising edge with in_push
// high and in_full low. result channel: the oldest result sits on the out_
// ports while out_empty is low and is transferred on an edge with out_pop
// high. one result per triple, in order: center, floor of the radius, turn
// direction and status (ok, collinear, center out of range).
//
// throughput: one triple per cycle unless the full result queue holds the
// pipelines. the pipeline length is set by the two restoring dividers (one
// quotient bit per stage, 3*COORD_WIDTH+3 stages) and the 32 stage square
// root pipeline.
//
// a five stage front computes the determinant terms and feeds a four entry
// queue; the back part runs the dividers and square root and writes a two
// entry result queue. when out_pop stays low the result queue fills, the
// back pipeline holds, then the front, and in_full rises; nothing is lost.
// reset empties both queues and all pipeline stages.
`default_nettype none
module circumcircle_from_three_points #(
  parameter int unsigned COORD_WIDTH = ccfp_pkg::CCFP_COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [COORD_WIDTH-1:0]       in_first_x,
  input  logic signed [COORD_WIDTH-1:0]       in_first_y,
  input  logic signed [COORD_WIDTH-1:0]       in_second_x,
  input  logic signed [COORD_WIDTH-1:0]       in_second_y,
  input  logic signed [COORD_WIDTH-1:0]       in_third_x,
  input  logic signed [COORD_WIDTH-1:0]       in_third_y,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic signed [ccfp_pkg::CENTER_W-1:0] out_center_x,
  output logic signed [ccfp_pkg::CENTER_W-1:0] out_center_y,
  output logic [ccfp_pkg::CENTER_W-1:0]       out_radius,
  output logic                                out_clockwise,
  output logic [1:0]                          out_status
);
  import ccfp_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned AW  = 2 * W + 3;
  localparam int unsigned BW  = 3 * W + 3;
  localparam int unsigned QDW = AW + 2 * BW + 2 * W + 1;
  localparam int unsigned RDW = $bits(result_t);

  logic                 f_ready, f_valid;
  logic signed [AW-1:0] f_a, q_a;
  logic signed [BW-1:0] f_b, f_c, q_b, q_c;
  logic signed [W-1:0]  f_x1, f_y1, q_x1, q_y1;
  logic                 f_cw, q_cw;
  logic                 q_full, q_empty;
  logic [QDW-1:0]       q_wdata, q_rdata;
  logic                 b_ready;
  logic                 r_valid;
  logic                 o_full;
  result_t              r_res, o_res;
  logic [RDW-1:0]       o_rdata;

  assign in_full = !f_ready;

  ccfp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_push),
    .in_ready  (f_ready),
    .x1        (in_first_x),
    .y1        (in_first_y),
    .x2        (in_second_x),
    .y2        (in_second_y),
    .x3        (in_third_x),
    .y3        (in_third_y),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .a_o       (f_a),
    .b_o       (f_b),
    .c_o       (f_c),
    .x1_o      (f_x1),
    .y1_o      (f_y1),
    .cw_o      (f_cw)
  );

  assign q_wdata = {f_a, f_b, f_c, f_x1, f_y1, f_cw};
  assign {q_a, q_b, q_c, q_x1, q_y1, q_cw} = q_rdata;

  ccfp_fifo #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_valid),
    .full    (q_full),
    .wr_data (q_wdata),
    .pop     (b_ready),
    .empty   (q_empty),
    .rd_data (q_rdata)
  );

  ccfp_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!q_empty),
    .in_ready  (b_ready),
    .a_i       (q_a),
    .b_i       (q_b),
    .c_i       (q_c),
    .x1_i      (q_x1),
    .y1_i      (q_y1),
    .cw_i      (q_cw),
    .res_valid (r_valid),
    .res_ready (!o_full),
    .res       (r_res)
  );

  ccfp_fifo #(.WIDTH(RDW), .DEPTH(OUT_DEPTH)) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (r_valid),
    .full    (o_full),
    .wr_data (r_res),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (o_rdata)
  );

  assign o_res         = o_rdata;
  assign out_center_x  = o_res.center_x;
  assign out_center_y  = o_res.center_y;
  assign out_radius    = o_res.radius;
  assign out_clockwise = o_res.clockwise;
  assign out_status    = o_res.status;

endmodule
`default_nettype wire

@@ rtl/core/ccfp_fifo.sv @@
`default_nettype none
`include "circumcircle_from_three_points_defines.svh"
module ccfp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ccfp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);
  import ccfp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `CCFP_ASSERT(a_count_max, count_r <= CW'(DEPTH), "fifo count above depth")
  `CCFP_ASSERT_NEXT(a_push_only, push_ok && !pop_ok, count_r == $past(count_r) + 1'b1, "count did not rise")
  `CCFP_ASSERT_NEXT(a_pop_only, pop_ok && !push_ok, count_r == $past(count_r) - 1'b1, "count did not fall")
  `CCFP_ASSERT_NEXT(a_both, push_ok && pop_ok, count_r == $past(count_r), "count moved on push and pop")

endmodule
`default_nettype wire

@@ rtl/core/ccfp_front.sv @@
`default_nettype none
module ccfp_front #(
  parameter int unsigned COORD_WIDTH = ccfp_pkg::CCFP_COORD_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_WIDTH-1:0]  x1,
  input  logic signed [COORD_WIDTH-1:0]  y1,
  input  logic signed [COORD_WIDTH-1:0]  x2,
  input  logic signed [COORD_WIDTH-1:0]  y2,
  input  logic signed [COORD_WIDTH-1:0]  x3,
  input  logic signed [COORD_WIDTH-1:0]  y3,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [2*COORD_WIDTH+2:0] a_o,
  output logic signed [3*COORD_WIDTH+2:0] b_o,
  output logic signed [3*COORD_WIDTH+2:0] c_o,
  output logic signed [COORD_WIDTH-1:0]  x1_o,
  output logic signed [COORD_WIDTH-1:0]  y1_o,
  output logic                           cw_o
);
  import ccfp_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned SW = 2 * W + 1;
  localparam int unsigned AW = 2 * W + 3;
  localparam int unsigned MW = 3 * W + 2;
  localparam int unsigned BW = 3 * W + 3;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1: coordinates and differences
  logic signed [W-1:0]  x1_1_r, y1_1_r, x2_1_r, y2_1_r, x3_1_r, y3_1_r;
  logic signed [DW-1:0] dx23_1_r, dy23_1_r, dx31_1_r, dy31_1_r, dx12_1_r, dy12_1_r;
  // stage 2: products
  logic signed [PW-1:0] pa0_2_r, pa1_2_r, pa2_2_r, pa3_2_r, pt0_2_r, pt1_2_r;
  logic signed [SW-1:0] qx1_2_r, qy1_2_r, qx2_2_r, qy2_2_r, qx3_2_r, qy3_2_r;
  logic signed [DW-1:0] dx23_2_r, dy23_2_r, dx31_2_r, dy31_2_r, dx12_2_r, dy12_2_r;
  logic signed [W-1:0]  x1_2_r, y1_2_r;
  // stage 3: sums
  logic signed [AW-1:0] a_3_r;
  logic signed [SW-1:0] s1_3_r, s2_3_r, s3_3_r;
  logic signed [DW-1:0] dx23_3_r, dy23_3_r, dx31_3_r, dy31_3_r, dx12_3_r, dy12_3_r;
  logic signed [W-1:0]  x1_3_r, y1_3_r;
  logic                 cw_3_r;
  logic signed [PW:0]   turn;
  // stage 4: weighted squares
  logic signed [MW-1:0] mb1_4_r, mb2_4_r, mb3_4_r, mc1_4_r, mc2_4_r, mc3_4_r;
  logic signed [AW-1:0] a_4_r;
  logic signed [W-1:0]  x1_4_r, y1_4_r;
  logic                 cw_4_r;

  assign en        = !(v5_r && !out_ready);
  assign in_ready  = en;
  assign out_valid = v5_r;
  assign turn      = (PW+1)'(pt0_2_r) - (PW+1)'(pt1_2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_1_r   <= x1;
      y1_1_r   <= y1;
      x2_1_r   <= x2;
      y2_1_r   <= y2;
      x3_1_r   <= x3;
      y3_1_r   <= y3;
      dx23_1_r <= DW'(x2) - DW'(x3);
      dy23_1_r <= DW'(y2) - DW'(y3);
      dx31_1_r <= DW'(x3) - DW'(x1);
      dy31_1_r <= DW'(y3) - DW'(y1);
      dx12_1_r <= DW'(x1) - DW'(x2);
      dy12_1_r <= DW'(y1) - DW'(y2);

      pa0_2_r  <= PW'(x1_1_r) * PW'(dy23_1_r);
      pa1_2_r  <= PW'(y1_1_r) * PW'(dx23_1_r);
      pa2_2_r  <= PW'(x2_1_r) * PW'(y3_1_r);
      pa3_2_r  <= PW'(x3_1_r) * PW'(y2_1_r);
      pt0_2_r  <= PW'(dy12_1_r) * PW'(dx23_1_r);
      pt1_2_r  <= PW'(dx12_1_r) * PW'(dy23_1_r);
      qx1_2_r  <= SW'(x1_1_r) * SW'(x1_1_r);
      qy1_2_r  <= SW'(y1_1_r) * SW'(y1_1_r);
      qx2_2_r  <= SW'(x2_1_r) * SW'(x2_1_r);
      qy2_2_r  <= SW'(y2_1_r) * SW'(y2_1_r);
      qx3_2_r  <= SW'(x3_1_r) * SW'(x3_1_r);
      qy3_2_r  <= SW'(y3_1_r) * SW'(y3_1_r);
      dx23_2_r <= dx23_1_r;
      dy23_2_r <= dy23_1_r;
      dx31_2_r <= dx31_1_r;
      dy31_2_r <= dy31_1_r;
      dx12_2_r <= dx12_1_r;
      dy12_2_r <= dy12_1_r;
      x1_2_r   <= x1_1_r;
      y1_2_r   <= y1_1_r;

      a_3_r    <= AW'(pa0_2_r) - AW'(pa1_2_r) + AW'(pa2_2_r) - AW'(pa3_2_r);
      s1_3_r   <= qx1_2_r + qy1_2_r;
      s2_3_r   <= qx2_2_r + qy2_2_r;
      s3_3_r   <= qx3_2_r + qy3_2_r;
      cw_3_r   <= !turn[PW] && (turn != '0);
      dx23_3_r <= dx23_2_r;
      dy23_3_r <= dy23_2_r;
      dx31_3_r <= dx31_2_r;
      dy31_3_r <= dy31_2_r;
      dx12_3_r <= dx12_2_r;
      dy12_3_r <= dy12_2_r;
      x1_3_r   <= x1_2_r;
      y1_3_r   <= y1_2_r;

      mb1_4_r  <= MW'(s1_3_r) * MW'(dy23_3_r);
      mb2_4_r  <= MW'(s2_3_r) * MW'(dy31_3_r);
      mb3_4_r  <= MW'(s3_3_r) * MW'(dy12_3_r);
      mc1_4_r  <= MW'(s1_3_r) * MW'(dx23_3_r);
      mc2_4_r  <= MW'(s2_3_r) * MW'(dx31_3_r);
      mc3_4_r  <= MW'(s3_3_r) * MW'(dx12_3_r);
      a_4_r    <= a_3_r;
      x1_4_r   <= x1_3_r;
      y1_4_r   <= y1_3_r;
      cw_4_r   <= cw_3_r;

      a_o      <= a_4_r;
      b_o      <= -(BW'(mb1_4_r) + BW'(mb2_4_r) + BW'(mb3_4_r));
      c_o      <= BW'(mc1_4_r) + BW'(mc2_4_r) + BW'(mc3_4_r);
      x1_o     <= x1_4_r;
      y1_o     <= y1_4_r;
      cw_o     <= cw_4_r;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ccfp_back.sv @@
`default_nettype none
module ccfp_back #(
  parameter int unsigned COORD_WIDTH = ccfp_pkg::CCFP_COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [2*COORD_WIDTH+2:0] a_i,
  input  logic signed [3*COORD_WIDTH+2:0] b_i,
  input  logic signed [3*COORD_WIDTH+2:0] c_i,
  input  logic signed [COORD_WIDTH-1:0]   x1_i,
  input  logic signed [COORD_WIDTH-1:0]   y1_i,
  input  logic                            cw_i,
  output logic                            res_valid,
  input  logic                            res_ready,
  output ccfp_pkg::result_t               res
);
  import ccfp_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned AW = 2 * W + 3;
  localparam int unsigned BW = 3 * W + 3;
  localparam int unsigned DW = AW + 1;
  localparam int unsigned NW = BW;
  localparam int unsigned QW = NW + 1;
  localparam int unsigned CW = CENTER_W;
  localparam int unsigned EW = DELTA_W;
  localparam int unsigned RW = ROOT_W + 2;

  logic en;

  // divider pipeline, stage 0 is the capture stage
  logic              vd_r   [NW+1];
  logic [DW-1:0]     dv_r   [NW+1];
  logic [DW-1:0]     rb_r   [NW+1];
  logic [DW-1:0]     rc_r   [NW+1];
  logic [NW-1:0]     nqb_r  [NW+1];
  logic [NW-1:0]     nqc_r  [NW+1];
  logic              negx_r [NW+1];
  logic              negy_r [NW+1];
  logic              col_r  [NW+1];
  logic              cwd_r  [NW+1];
  logic signed [W-1:0] x1d_r [NW+1];
  logic signed [W-1:0] y1d_r [NW+1];

  logic              a_neg;
  logic [AW-1:0]     a_mag;
  logic [BW-1:0]     b_mag;
  logic [BW-1:0]     c_mag;

  // sign, range, offset and square stages
  logic                vp1_r, vp2_r, vp3_r;
  logic signed [QW-1:0] qx_p1_r, qy_p1_r;
  logic                col_p1_r, cw_p1_r;
  logic signed [W-1:0] x1_p1_r, y1_p1_r;
  logic signed [63:0]  qx64, qy64;
  logic                in_rng;
  status_t             st_nxt;
  logic [CW-1:0]       cx_p2_r, cy_p2_r, cx_p3_r, cy_p3_r;
  status_t             st_p2_r, st_p3_r;
  logic                cw_p2_r, cw_p3_r;
  logic signed [EW-1:0] dx_p2_r, dy_p2_r;
  logic signed [D2_W-1:0] sqx_p3_r, sqy_p3_r;

  // square root pipeline, stage 0 holds the squared distance
  logic              vs_r   [ROOT_W+1];
  logic [D2_W-1:0]   rad_r  [ROOT_W+1];
  logic [RW-1:0]     rm_r   [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [CW-1:0]     cxs_r  [ROOT_W+1];
  logic [CW-1:0]     cys_r  [ROOT_W+1];
  status_t           sts_r  [ROOT_W+1];
  logic              cws_r  [ROOT_W+1];

  assign en        = !(vs_r[ROOT_W] && !res_ready);
  assign in_ready  = en;
  assign res_valid = vs_r[ROOT_W];

  assign a_neg = a_i[AW-1];
  assign a_mag = a_neg ? AW'(-a_i) : AW'(a_i);
  assign b_mag = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);
  assign c_mag = c_i[BW-1] ? BW'(-c_i) : BW'(c_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]   <= {a_mag, 1'b0};
      rb_r[0]   <= '0;
      rc_r[0]   <= '0;
      nqb_r[0]  <= b_mag;
      nqc_r[0]  <= c_mag;
      negx_r[0] <= (!b_i[BW-1] && (b_i != '0)) ^ a_neg;
      negy_r[0] <= (!c_i[BW-1] && (c_i != '0)) ^ a_neg;
      col_r[0]  <= (a_i == '0);
      cwd_r[0]  <= cw_i;
      x1d_r[0]  <= x1_i;
      y1d_r[0]  <= y1_i;
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_div
    logic [DW:0] tb, tc;
    logic        geb, gec;

    assign tb  = {rb_r[k-1], nqb_r[k-1][NW-1]};
    assign tc  = {rc_r[k-1], nqc_r[k-1][NW-1]};
    assign geb = (tb >= {1'b0, dv_r[k-1]});
    assign gec = (tc >= {1'b0, dv_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k] <= 1'b0;
      end else if (en) begin
        vd_r[k] <= vd_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rb_r[k]   <= geb ? DW'(tb - {1'b0, dv_r[k-1]}) : DW'(tb);
        rc_r[k]   <= gec ? DW'(tc - {1'b0, dv_r[k-1]}) : DW'(tc);
        nqb_r[k]  <= {nqb_r[k-1][NW-2:0], geb};
        nqc_r[k]  <= {nqc_r[k-1][NW-2:0], gec};
        dv_r[k]   <= dv_r[k-1];
        negx_r[k] <= negx_r[k-1];
        negy_r[k] <= negy_r[k-1];
        col_r[k]  <= col_r[k-1];
        cwd_r[k]  <= cwd_r[k-1];
        x1d_r[k]  <= x1d_r[k-1];
        y1d_r[k]  <= y1d_r[k-1];
      end
    end
  end

  assign qx64   = 64'(qx_p1_r);
  assign qy64   = 64'(qy_p1_r);
  assign in_rng = (qx64 >= CENTER_MIN) && (qx64 <= CENTER_MAX) &&
                  (qy64 >= CENTER_MIN) && (qy64 <= CENTER_MAX);

  always_comb begin
    if (col_p1_r) begin
      st_nxt = STATUS_COLLINEAR;
    end else if (!in_rng) begin
      st_nxt = STATUS_RANGE;
    end else begin
      st_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vp3_r <= 1'b0;
      vs_r[0] <= 1'b0;
    end else if (en) begin
      vp1_r <= vd_r[NW];
      vp2_r <= vp1_r;
      vp3_r <= vp2_r;
      vs_r[0] <= vp3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_p1_r  <= negx_r[NW] ? -$signed({1'b0, nqb_r[NW]}) : $signed({1'b0, nqb_r[NW]});
      qy_p1_r  <= negy_r[NW] ? -$signed({1'b0, nqc_r[NW]}) : $signed({1'b0, nqc_r[NW]});
      col_p1_r <= col_r[NW];
      cw_p1_r  <= cwd_r[NW];
      x1_p1_r  <= x1d_r[NW];
      y1_p1_r  <= y1d_r[NW];

      cx_p2_r  <= qx64[CW-1:0];
      cy_p2_r  <= qy64[CW-1:0];
      st_p2_r  <= st_nxt;
      cw_p2_r  <= cw_p1_r;
      dx_p2_r  <= EW'($signed(qx64[CW-1:0])) - EW'(x1_p1_r);
      dy_p2_r  <= EW'($signed(qy64[CW-1:0])) - EW'(y1_p1_r);

      sqx_p3_r <= D2_W'(dx_p2_r) * D2_W'(dx_p2_r);
      sqy_p3_r <= D2_W'(dy_p2_r) * D2_W'(dy_p2_r);
      cx_p3_r  <= cx_p2_r;
      cy_p3_r  <= cy_p2_r;
      st_p3_r  <= st_p2_r;
      cw_p3_r  <= cw_p2_r;

      rad_r[0]  <= D2_W'(sqx_p3_r) + D2_W'(sqy_p3_r);
      rm_r[0]   <= '0;
      root_r[0] <= '0;
      cxs_r[0]  <= cx_p3_r;
      cys_r[0]  <= cy_p3_r;
      sts_r[0]  <= st_p3_r;
      cws_r[0]  <= cw_p3_r;
    end
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic          ge;

    assign t     = {rm_r[k-1], rad_r[k-1][D2_W-1 -: 2]};
    assign trial = {2'b00, root_r[k-1], 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k] <= 1'b0;
      end else if (en) begin
        vs_r[k] <= vs_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[k]   <= ge ? RW'(t - trial) : RW'(t);
        root_r[k] <= {root_r[k-1][ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_r[k-1][D2_W-3:0], 2'b00};
        cxs_r[k]  <= cxs_r[k-1];
        cys_r[k]  <= cys_r[k-1];
        sts_r[k]  <= sts_r[k-1];
        cws_r[k]  <= cws_r[k-1];
      end
    end
  end

  always_comb begin
    res.clockwise = cws_r[ROOT_W];
    res.status    = sts_r[ROOT_W];
    if (sts_r[ROOT_W] == STATUS_OK) begin
      res.center_x = $signed(cxs_r[ROOT_W]);
      res.center_y = $signed(cys_r[ROOT_W]);
      res.radius   = root_r[ROOT_W][CW-1:0];
    end else begin
      res.center_x = '0;
      res.center_y = '0;
      res.radius   = '0;
    end
  end

endmodule
`default_nettype wire

@@ verif/circle_result_checker.sv @@
`timescale 1ns / 1ps
module circle_result_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  logic                                 in_full,
  input  logic signed [15:0]                   in_first_x,
  input  logic signed [15:0]                   in_first_y,
  input  logic signed [15:0]                   in_second_x,
  input  logic signed [15:0]                   in_second_y,
  input  logic signed [15:0]                   in_third_x,
  input  logic signed [15:0]                   in_third_y,
  input  logic                                 out_pop,
  input  logic                                 out_empty,
  input  logic signed [ccfp_pkg::CENTER_W-1:0] out_center_x,
  input  logic signed [ccfp_pkg::CENTER_W-1:0] out_center_y,
  input  logic [ccfp_pkg::CENTER_W-1:0]        out_radius,
  input  logic                                 out_clockwise,
  input  logic [1:0]                           out_status,
  output int                                   error_count,
  output int                                   pending_count,
  output int                                   result_count,
  output int                                   status_seen [3]
);
  import ccfp_pkg::*;

  result_t circle_queue [$];

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic result_t predict_circle(longint x1, longint y1, longint x2,
                                             longint y2, longint x3, longint y3);
    result_t r;
    longint s1, s2, s3, a, b, c, turn, cx, cy, dx, dy;
    s1 = x1 * x1 + y1 * y1;
    s2 = x2 * x2 + y2 * y2;
    s3 = x3 * x3 + y3 * y3;
    a = x1 * (y2 - y3) - y1 * (x2 - x3) + x2 * y3 - x3 * y2;
    b = s1 * (y3 - y2) + s2 * (y1 - y3) + s3 * (y2 - y1);
    c = s1 * (x2 - x3) + s2 * (x3 - x1) + s3 * (x1 - x2);
    turn = (y2 - y1) * (x3 - x2) - (x2 - x1) * (y3 - y2);
    r = '0;
    r.clockwise = (turn > 0);
    if (a == 0) begin
      r.status = STATUS_COLLINEAR;
    end else begin
      cx = (-b) / (2 * a);
      cy = (-c) / (2 * a);
      if (cx < CENTER_MIN || cx > CENTER_MAX || cy < CENTER_MIN || cy > CENTER_MAX) begin
        r.status = STATUS_RANGE;
      end else begin
        dx = cx - x1;
        dy = cy - y1;
        r.status = STATUS_OK;
        r.center_x = cx[CENTER_W-1:0];
        r.center_y = cy[CENTER_W-1:0];
        r.radius = CENTER_W'(isqrt64(longint'(dx * dx) + longint'(dy * dy)));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d expected %0d (result %0d)", what, got, want,
             result_count);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    result_count = 0;
    pending_count = 0;
    status_seen = '{0, 0, 0};
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && in_push && !in_full)
      circle_queue = {circle_queue, predict_circle(in_first_x, in_first_y, in_second_x,
                                                   in_second_y, in_third_x, in_third_y)};
    if (rst_n && out_pop && !out_empty) begin
      if (circle_queue.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = circle_queue.pop_front();
        if (out_center_x !== want.center_x)
          report_mismatch("center_x", out_center_x, want.center_x);
        if (out_center_y !== want.center_y)
          report_mismatch("center_y", out_center_y, want.center_y);
        if (out_radius !== want.radius) report_mismatch("radius", out_radius, want.radius);
        if (out_clockwise !== want.clockwise)
          report_mismatch("clockwise", out_clockwise, want.clockwise);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (want.status <= STATUS_RANGE) status_seen[want.status]++;
      end
      result_count++;
    end
    pending_count = circle_queue.size();
  end

endmodule

@@ verif/circumcircle_from_three_points_test.sv @@
`timescale 1ns / 1ps
module circumcircle_from_three_points_test;
  import ccfp_pkg::*;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic signed [15:0] in_first_x, in_first_y, in_second_x, in_second_y;
  logic signed [15:0] in_third_x, in_third_y;
  logic out_pop;
  logic out_empty;
  logic signed [CENTER_W-1:0] out_center_x, out_center_y;
  logic [CENTER_W-1:0] out_radius;
  logic out_clockwise;
  logic [1:0] out_status;
  int error_count, pending_count, result_count;
  int status_seen [3];
  int cycle_count;
  int sent_count;
  bit calm_phase;
  bit hold_off;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;

  circumcircle_from_three_points DUT (.*);

  circle_result_checker checker_inst (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("circumcircle_from_three_points_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_pop = 0;
    hold_off = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_pop <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        out_pop <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        out_pop <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_triple(logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
                             logic [15:0] y2, logic [15:0] x3, logic [15:0] y3);
    int gap;
    if (!calm_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1;
    in_first_x <= x1;
    in_first_y <= y1;
    in_second_x <= x2;
    in_second_y <= y2;
    in_third_x <= x3;
    in_third_y <= y3;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic [15:0] rand_coord(int span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  initial begin
    logic [15:0] x1, y1, x2, y2, x3, y3;
    int span, kind, tail;
    rst_n = 0;
    in_push = 0;
    {in_first_x, in_first_y, in_second_x, in_second_y, in_third_x, in_third_y} = '0;
    calm_phase = 0;
    sent_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_triple(0, 0, 10, 0, 0, 10);
    send_triple(0, 0, 0, 10, 10, 0);
    send_triple(0, 0, 1, 1, 2, 2);
    send_triple(5, 5, 5, 5, 5, 5);
    send_triple(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_triple(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_triple(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    send_triple(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0001, 16'hffff);
    send_triple(0, 0, 1, 0, 16'h7fff, 1);
    send_triple(16'h8000, 0, 16'h7fff, 1, 16'h7fff, 0);
    send_triple(0, 0, 1, 1, 16'h7fff, 16'h7ffe);
    send_triple(16'h8000, 16'h8000, 16'h8001, 16'h8000, 16'h8000, 16'h8001);
    send_triple(3, 7, 3, 7, 9, 1);
    send_triple(16'h7fff, 0, 0, 16'h7fff, 16'h8000, 0);
    send_triple(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0);

    tail = RANDOM_ITEMS - 150;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_off = 1;
      if (i == tail) calm_phase = 1;
      kind = $urandom_range(0, 9);
      span = (kind < 3) ? 0 : (kind < 6) ? 100 : (kind < 8) ? 3000 : 4;
      x1 = rand_coord(span);
      y1 = rand_coord(span);
      x2 = rand_coord(span);
      y2 = rand_coord(span);
      x3 = rand_coord(span);
      y3 = rand_coord(span);
      if (kind == 9 && $urandom_range(0, 1)) begin
        x3 = x2 + (x2 - x1);
        y3 = y2 + (y2 - y1);
      end
      send_triple(x1, y1, x2, y2, x3, y3);
    end
    in_push <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d triples, checked %0d results", sent_count, result_count);
    $display("status mix: ok %0d, collinear %0d, out of range %0d",
             status_seen[0], status_seen[1], status_seen[2]);
    if (error_count == 0 && pending_count == 0) begin
      $display("circumcircle_from_three_points_test: clean");
    end else begin
      $display("circumcircle_from_three_points_test: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ccfp_pkg.sv
rtl/core/ccfp_fifo.sv
rtl/core/ccfp_front.sv
rtl/core/ccfp_back.sv
rtl/core/circumcircle_from_three_points.sv
verif/circle_result_checker.sv
verif/circumcircle_from_three_points_test.sv
